/* hw/rtl/lkv_pkg.sv */
// Types and constants shared by the LRU key-value cache core.
// No dependencies; every other file refers to this package by scoped names.
package lkv_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
  localparam logic             REQ_GET    = 1'b0;
  localparam logic             REQ_PUT    = 1'b1;
  localparam logic [VAL_W-1:0] MISS_VALUE = '1;

  typedef struct packed {
    logic                    req_type;
    logic [KEY_W-1:0]        lookup_key;
    logic signed [VAL_W-1:0] write_value;
  } req_t;

  typedef struct packed {
    logic                    hit;
    logic signed [VAL_W-1:0] read_value;
    logic                    evicted;
    logic [KEY_W-1:0]        evicted_key;
  } rsp_t;

  typedef struct packed {
    logic                    valid;
    logic [KEY_W-1:0]        key;
    logic signed [VAL_W-1:0] value;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } state_t;

endpackage

/* hw/rtl/lkv_cell.sv */
// One entry of the recency-ordered chain: holds a key/value word and compares it.
// Depends on lkv_pkg. Position in the chain is its recency rank (0 = most recent).
module lkv_cell #(
  parameter int IDX = 0,
  parameter int IW  = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          shift_en,
  input  logic [IW-1:0]                 limit,
  input  lkv_pkg::entry_t               src,
  input  logic [lkv_pkg::KEY_W-1:0]     key,
  output lkv_pkg::entry_t               entry,
  output logic                          match
);

  lkv_pkg::entry_t entry_r;
  logic            take;

  // take the neighbor's word when this cell lies inside the shifted span
  assign take  = shift_en && (IW'(IDX) <= limit);
  assign match = entry_r.valid && (entry_r.key == key);
  assign entry = entry_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.valid <= 1'b0;
    end else if (take) begin
      entry_r.valid <= src.valid;
    end
    if (take) begin
      entry_r.key   <= src.key;
      entry_r.value <= src.value;
    end
  end

endmodule

/* hw/rtl/lkv_select.sv */
// Reduces the per-cell compare results to hit, position and stored value,
// and picks the key of the oldest live cell. Depends on lkv_pkg.
module lkv_select #(
  parameter int MAX_ENTRIES = 16,
  parameter int IW          = 4
) (
  input  logic [MAX_ENTRIES-1:0]        match,
  input  lkv_pkg::entry_t               cells [MAX_ENTRIES],
  input  logic [IW-1:0]                 oldest_idx,
  output logic                          hit,
  output logic [IW-1:0]                 pos,
  output logic [lkv_pkg::VAL_W-1:0]     value,
  output logic [lkv_pkg::KEY_W-1:0]     oldest_key
);

  // keys are unique, so at most one match bit is set: OR the selected fields
  always_comb begin
    hit   = 1'b0;
    pos   = '0;
    value = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit   = hit | match[i];
      pos   = pos | (match[i] ? IW'(i) : '0);
      value = value | (match[i] ? cells[i].value : '0);
    end
  end

  assign oldest_key = cells[oldest_idx].key;

endmodule

/* hw/rtl/lru_key_value_cache_core.sv */
// Top level of the fully associative LRU key-value cache.
// Depends on lkv_pkg, lkv_cell and lkv_select.
//
//   channel  | ports                  | handshake
//   ---------+------------------------+------------------------------------
//   request  | start, busy, in_req    | taken when start high and busy low
//   result   | out_valid, out_rsp     | one-cycle strobe, always taken
//   config   | cfg_we, cfg_wdata      | capacity written when cfg_we high
//
// Each request passes through a compare state, which matches the key against
// every cell and reduces the matches, then an update state, which shifts the
// recency chain on a hit or a put. busy is high only in the compare cycle, so
// a new word is taken in the update state. The result strobe comes in the
// cycle after the compare. Synchronous reset empties the chain and sets the
// capacity to 16. The receiver cannot stall the result.
module lru_key_value_cache_core #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  lkv_pkg::req_t                 in_req,
  output logic                          out_valid,
  output lkv_pkg::rsp_t                 out_rsp,
  input  logic                          cfg_we,
  input  logic [lkv_pkg::CAP_W-1:0]     cfg_wdata
);

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int EW = (CW > lkv_pkg::CAP_W) ? CW : lkv_pkg::CAP_W;

  lkv_pkg::state_t              state_r, state_nxt;
  lkv_pkg::req_t                req_r;
  logic [lkv_pkg::CAP_W-1:0]    cfg_cap_r;
  logic [CW-1:0]                live_count_r, live_count_nxt;
  logic                         upd_en_r, upd_en_nxt;
  logic [IW-1:0]                limit_r, limit_nxt;
  lkv_pkg::entry_t              head_r, head_nxt;
  logic                         inc_r, inc_nxt;
  logic                         out_valid_r;
  lkv_pkg::rsp_t                out_rsp_r, rsp_nxt;

  logic                         accept;
  logic                         shift_en;
  logic                         is_put;
  logic                         full;
  logic [IW-1:0]                oldest_idx;

  lkv_pkg::entry_t              cells [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]       match;
  logic [MAX_ENTRIES-1:0]       valid_vec;
  logic                         sel_hit;
  logic [IW-1:0]                sel_pos;
  logic [lkv_pkg::VAL_W-1:0]    sel_value;
  logic [lkv_pkg::KEY_W-1:0]    sel_oldest_key;

  // ---------------------------------------------------------------- control

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lkv_pkg::ST_IDLE: if (start) state_nxt = lkv_pkg::ST_CMP;
      lkv_pkg::ST_CMP:  state_nxt = lkv_pkg::ST_UPD;
      lkv_pkg::ST_UPD:  state_nxt = start ? lkv_pkg::ST_CMP : lkv_pkg::ST_IDLE;
      default:          state_nxt = lkv_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy     = 1'b0;
    shift_en = 1'b0;
    unique case (state_r)
      lkv_pkg::ST_IDLE: busy = 1'b0;
      lkv_pkg::ST_CMP:  busy = 1'b1;
      lkv_pkg::ST_UPD:  shift_en = upd_en_r;
      default:          busy = 1'b0;
    endcase
  end

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= lkv_pkg::ST_IDLE;
      cfg_cap_r    <= lkv_pkg::CAP_RESET;
      live_count_r <= '0;
      out_valid_r  <= 1'b0;
      upd_en_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      live_count_r <= live_count_nxt;
      out_valid_r  <= (state_r == lkv_pkg::ST_CMP);
      if (cfg_we) begin
        cfg_cap_r <= cfg_wdata;
      end
      if (state_r == lkv_pkg::ST_CMP) begin
        upd_en_r <= upd_en_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req;
    end
    if (state_r == lkv_pkg::ST_CMP) begin
      limit_r   <= limit_nxt;
      head_r    <= head_nxt;
      inc_r     <= inc_nxt;
      out_rsp_r <= rsp_nxt;
    end
  end

  // ------------------------------------------------------------- cell chain

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    lkv_pkg::entry_t src;
    if (g == 0) begin : g_head
      assign src = head_r;
    end else begin : g_link
      assign src = cells[g-1];
    end

    lkv_cell #(
      .IDX (g),
      .IW  (IW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .limit    (limit_r),
      .src      (src),
      .key      (req_r.lookup_key),
      .entry    (cells[g]),
      .match    (match[g])
    );

    assign valid_vec[g] = cells[g].valid;
  end

  lkv_select #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .IW          (IW)
  ) u_select (
    .match      (match),
    .cells      (cells),
    .oldest_idx (oldest_idx),
    .hit        (sel_hit),
    .pos        (sel_pos),
    .value      (sel_value),
    .oldest_key (sel_oldest_key)
  );

  // ------------------------------------------------------- compare decision

  // capacity zero acts as one; above MAX_ENTRIES it saturates
  always_comb begin
    full = (live_count_r == CW'(MAX_ENTRIES));
    if (cfg_cap_r == '0) begin
      full = full || (live_count_r != '0);
    end else begin
      full = full || (EW'(live_count_r) >= EW'(cfg_cap_r));
    end
  end

  // the oldest live entry sits at the end of the occupied span
  assign oldest_idx = IW'(live_count_r - CW'(1));
  assign is_put     = (req_r.req_type == lkv_pkg::REQ_PUT);

  always_comb begin
    rsp_nxt.hit         = sel_hit;
    rsp_nxt.evicted     = is_put && !sel_hit && full;
    rsp_nxt.evicted_key = rsp_nxt.evicted ? sel_oldest_key : '0;
    if (is_put) begin
      rsp_nxt.read_value = '0;
    end else if (sel_hit) begin
      rsp_nxt.read_value = sel_value;
    end else begin
      rsp_nxt.read_value = lkv_pkg::MISS_VALUE;
    end

    upd_en_nxt = sel_hit || is_put;
    inc_nxt    = is_put && !sel_hit && !full;

    // hit: rotate the matching cell to the front; miss put: push onto the front
    if (sel_hit) begin
      limit_nxt = sel_pos;
    end else if (full) begin
      limit_nxt = oldest_idx;
    end else begin
      limit_nxt = IW'(live_count_r);
    end

    head_nxt.valid = 1'b1;
    head_nxt.key   = req_r.lookup_key;
    head_nxt.value = is_put ? req_r.write_value : sel_value;
  end

  assign live_count_nxt = (shift_en && inc_r) ? live_count_r + CW'(1) : live_count_r;

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // ------------------------------------------------------------- assertions

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_count_r <= CW'(MAX_ENTRIES))
    else $error("live count above MAX_ENTRIES");

  a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == int'(live_count_r))
    else $error("cell valid bits disagree with live count");

  a_result_timing: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##2 out_valid)
    else $error("result strobe missing two cycles after accept");

  a_evict_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.evicted) |-> (!out_rsp.hit && out_rsp.read_value == '0))
    else $error("eviction reported on a hit or a get");

  a_miss_no_shift: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_rsp.hit && out_rsp.read_value == lkv_pkg::MISS_VALUE
      && !out_rsp.evicted && !$past(is_put)) |-> !shift_en)
    else $error("chain shifted on a get miss");

endmodule
